@@ src/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, off while rst is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen on a clk edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ src/sckd_pkg.sv @@
// Types, key codes and decode functions for the scan code keyboard decoder
package sckd_pkg;

   typedef struct packed {
      logic [7:0] raw_byte;
      logic       key_released;
   } sckd_req_type;

   typedef struct packed {
      logic       key_valid;
      logic [8:0] key_code;
      logic [7:0] scan_code;
      logic       key_action;
      logic [5:0] modifier_bits;
      logic       char_valid;
      logic [6:0] char_code;
      logic       char_is_text;
   } sckd_rsp_type;

   localparam logic [7:0] PREFIX_BYTE = 8'hE0;
   localparam logic [7:0] SCAN_MASK   = 8'h7F;
   localparam logic [7:0] EXT_BIT     = 8'h80;

   localparam logic [8:0] CASE_OFFSET = 9'd32;
   localparam logic [8:0] CHAR_ZERO   = 9'd48;

   localparam logic [8:0] KEY_NONE   = 9'd0;
   localparam logic [8:0] KEY_SPACE  = 9'd32;
   localparam logic [8:0] KEY_GRAVE  = 9'd96;
   localparam logic [8:0] KEY_A      = 9'd65;
   localparam logic [8:0] KEY_Z      = 9'd90;
   localparam logic [8:0] KEY_ESC    = 9'd256;
   localparam logic [8:0] KEY_ENTER  = 9'd257;
   localparam logic [8:0] KEY_TAB    = 9'd258;
   localparam logic [8:0] KEY_BKSP   = 9'd259;
   localparam logic [8:0] KEY_INS    = 9'd260;
   localparam logic [8:0] KEY_DEL    = 9'd261;
   localparam logic [8:0] KEY_RIGHT  = 9'd262;
   localparam logic [8:0] KEY_LEFT   = 9'd263;
   localparam logic [8:0] KEY_DOWN   = 9'd264;
   localparam logic [8:0] KEY_UP     = 9'd265;
   localparam logic [8:0] KEY_PGUP   = 9'd266;
   localparam logic [8:0] KEY_PGDN   = 9'd267;
   localparam logic [8:0] KEY_HOME   = 9'd268;
   localparam logic [8:0] KEY_END    = 9'd269;
   localparam logic [8:0] KEY_CAPS   = 9'd280;
   localparam logic [8:0] KEY_SCROLL = 9'd281;
   localparam logic [8:0] KEY_NUM    = 9'd282;
   localparam logic [8:0] KEY_F1     = 9'd290;
   localparam logic [8:0] KEY_KP0    = 9'd320;
   localparam logic [8:0] KEY_KP9    = 9'd329;
   localparam logic [8:0] KEY_KPDEC  = 9'd330;
   localparam logic [8:0] KEY_KPDIV  = 9'd331;
   localparam logic [8:0] KEY_KPMUL  = 9'd332;
   localparam logic [8:0] KEY_KPSUB  = 9'd333;
   localparam logic [8:0] KEY_KPADD  = 9'd334;
   localparam logic [8:0] KEY_KPENT  = 9'd335;
   localparam logic [8:0] KEY_LSHIFT = 9'd340;
   localparam logic [8:0] KEY_LCTRL  = 9'd341;
   localparam logic [8:0] KEY_LALT   = 9'd342;
   localparam logic [8:0] KEY_LSUPER = 9'd343;
   localparam logic [8:0] KEY_RSHIFT = 9'd344;
   localparam logic [8:0] KEY_RCTRL  = 9'd345;
   localparam logic [8:0] KEY_RALT   = 9'd346;
   localparam logic [8:0] KEY_RSUPER = 9'd347;
   localparam logic [8:0] KEY_MENU   = 9'd348;

   localparam int HELD_CAPS = 8;
   localparam int HELD_NUM  = 9;

   function automatic logic [8:0] scan_to_key(input logic [7:0] scan);
      logic [8:0] key;
      unique case (scan)
         8'h1e: key = 9'("A");
         8'h30: key = 9'("B");
         8'h2e: key = 9'("C");
         8'h20: key = 9'("D");
         8'h12: key = 9'("E");
         8'h21: key = 9'("F");
         8'h22: key = 9'("G");
         8'h23: key = 9'("H");
         8'h17: key = 9'("I");
         8'h24: key = 9'("J");
         8'h25: key = 9'("K");
         8'h26: key = 9'("L");
         8'h32: key = 9'("M");
         8'h31: key = 9'("N");
         8'h18: key = 9'("O");
         8'h19: key = 9'("P");
         8'h10: key = 9'("Q");
         8'h13: key = 9'("R");
         8'h1f: key = 9'("S");
         8'h14: key = 9'("T");
         8'h16: key = 9'("U");
         8'h2f: key = 9'("V");
         8'h11: key = 9'("W");
         8'h2d: key = 9'("X");
         8'h15: key = 9'("Y");
         8'h2c: key = 9'("Z");
         8'h02: key = 9'("1");
         8'h03: key = 9'("2");
         8'h04: key = 9'("3");
         8'h05: key = 9'("4");
         8'h06: key = 9'("5");
         8'h07: key = 9'("6");
         8'h08: key = 9'("7");
         8'h09: key = 9'("8");
         8'h0a: key = 9'("9");
         8'h0b: key = 9'("0");
         8'h1c: key = KEY_ENTER;
         8'h01: key = KEY_ESC;
         8'h0e: key = KEY_BKSP;
         8'h0f: key = KEY_TAB;
         8'h39: key = KEY_SPACE;
         8'h0c: key = 9'("-");
         8'h0d: key = 9'("=");
         8'h1a: key = 9'("[");
         8'h1b: key = 9'("]");
         8'h2b: key = 9'd92;
         8'h27: key = 9'(";");
         8'h28: key = 9'd39;
         8'h29: key = KEY_GRAVE;
         8'h33: key = 9'(",");
         8'h34: key = 9'(".");
         8'h35: key = 9'("/");
         8'h3a: key = KEY_CAPS;
         8'h3b: key = KEY_F1;
         8'h3c: key = KEY_F1 + 9'd1;
         8'h3d: key = KEY_F1 + 9'd2;
         8'h3e: key = KEY_F1 + 9'd3;
         8'h3f: key = KEY_F1 + 9'd4;
         8'h40: key = KEY_F1 + 9'd5;
         8'h41: key = KEY_F1 + 9'd6;
         8'h42: key = KEY_F1 + 9'd7;
         8'h43: key = KEY_F1 + 9'd8;
         8'h44: key = KEY_F1 + 9'd9;
         8'h57: key = KEY_F1 + 9'd10;
         8'h58: key = KEY_F1 + 9'd11;
         8'hd2: key = KEY_INS;
         8'hc7: key = KEY_HOME;
         8'hc9: key = KEY_PGUP;
         8'hd3: key = KEY_DEL;
         8'hd1: key = KEY_PGDN;
         8'hcd: key = KEY_RIGHT;
         8'hcb: key = KEY_LEFT;
         8'hd0: key = KEY_DOWN;
         8'hc8: key = KEY_UP;
         8'h45: key = KEY_NUM;
         8'hb5: key = KEY_KPDIV;
         8'h37: key = KEY_KPMUL;
         8'h4a: key = KEY_KPSUB;
         8'h4e: key = KEY_KPADD;
         8'h9c: key = KEY_KPENT;
         8'h4f: key = KEY_KP0 + 9'd1;
         8'h50: key = KEY_KP0 + 9'd2;
         8'h51: key = KEY_KP0 + 9'd3;
         8'h4b: key = KEY_KP0 + 9'd4;
         8'h4c: key = KEY_KP0 + 9'd5;
         8'h4d: key = KEY_KP0 + 9'd6;
         8'h47: key = KEY_KP0 + 9'd7;
         8'h48: key = KEY_KP0 + 9'd8;
         8'h49: key = KEY_KP9;
         8'h52: key = KEY_KP0;
         8'h53: key = KEY_KPDEC;
         8'h1d: key = KEY_LCTRL;
         8'h2a: key = KEY_LSHIFT;
         8'h38: key = KEY_LALT;
         8'h9d: key = KEY_RCTRL;
         8'h36: key = KEY_RSHIFT;
         8'hcf: key = KEY_END;
         8'hb8: key = KEY_RALT;
         8'hdb: key = KEY_LSUPER;
         8'hdc: key = KEY_RSUPER;
         8'hdd: key = KEY_MENU;
         8'h46: key = KEY_SCROLL;
         default: key = KEY_NONE;
      endcase
      return key;
   endfunction

   function automatic logic [9:0] held_mask(input logic [8:0] key);
      logic [9:0] mask;
      mask = '0;
      if (key >= KEY_LSHIFT && key <= KEY_RSUPER) begin
         mask = 10'b1 << 4'(key - KEY_LSHIFT);
      end else if (key == KEY_CAPS) begin
         mask[HELD_CAPS] = 1'b1;
      end else if (key == KEY_NUM) begin
         mask[HELD_NUM] = 1'b1;
      end
      return mask;
   endfunction

   function automatic logic [6:0] shifted_char(input logic [6:0] c);
      logic [6:0] s;
      unique case (c)
         7'("1"):  s = 7'("!");
         7'("2"):  s = 7'("@");
         7'("3"):  s = 7'("#");
         7'("4"):  s = 7'("$");
         7'("5"):  s = 7'("%");
         7'("6"):  s = 7'("^");
         7'("7"):  s = 7'("&");
         7'("8"):  s = 7'("*");
         7'("9"):  s = 7'("(");
         7'("0"):  s = 7'(")");
         7'("-"):  s = 7'("_");
         7'("="):  s = 7'("+");
         7'("["):  s = 7'("{");
         7'("]"):  s = 7'("}");
         7'd92:    s = 7'("|");
         7'(";"):  s = 7'(":");
         7'd39:    s = 7'd34;
         7'(","):  s = 7'("<");
         7'("."):  s = 7'(">");
         7'("/"):  s = 7'("?");
         7'd96:    s = 7'("~");
         default:  s = c;
      endcase
      return s;
   endfunction

   // mods: bit0 shift, bit4 caps, bit5 num
   function automatic logic [6:0] key_char(input logic [8:0] key, input logic [5:0] mods);
      logic [6:0] c;
      if (key >= KEY_A && key <= KEY_Z) begin
         c = (mods[0] != mods[4]) ? key[6:0] : 7'(key + CASE_OFFSET);
      end else if (key >= KEY_KP0 && key <= KEY_KP9) begin
         c = mods[5] ? 7'(CHAR_ZERO + (key - KEY_KP0)) : 7'd0;
      end else if (key == KEY_KPADD) begin
         c = 7'("+");
      end else if (key == KEY_KPSUB) begin
         c = 7'("-");
      end else if (key == KEY_KPMUL) begin
         c = 7'("*");
      end else if (key == KEY_KPDIV) begin
         c = 7'("/");
      end else if (key == KEY_KPDEC) begin
         c = mods[5] ? 7'(".") : 7'd0;
      end else if (key < KEY_SPACE || key > KEY_GRAVE) begin
         c = 7'd0;
      end else begin
         c = mods[0] ? shifted_char(key[6:0]) : key[6:0];
      end
      return c;
   endfunction

endpackage

@@ src/scancode_keyboard_decoder_unit.sv @@
// Scan code keyboard decoder: set-1 bytes in, key events and characters out
// An accepted req item is registered into the result register, or into the skid register while rsp_stall holds it.
// Throughput: 1 item per cycle while req_stall is low; decode is one table lookup and mask logic.
// A two-entry output (result register plus skid register) absorbs rsp_stall.
// Reset clears prefix, lock and held-key state and empties the output.
module scancode_keyboard_decoder_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sckd_pkg::sckd_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sckd_pkg::sckd_rsp_type rsp_data
);
   import sckd_pkg::*;

   logic [1:0]   prefix_ff, prefix_in;
   logic [1:0]   lock_ff, lock_in;
   logic [9:0]   down_ff, down_in;
   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   sckd_rsp_type out_ff, out_in;
   sckd_rsp_type skid_ff;

   logic         accept;
   logic         out_adv;
   logic         chan;
   logic         press;
   logic         is_prefix;
   logic [1:0]   chan_mask;
   logic [7:0]   scan;
   logic [8:0]   key;
   logic         mapped;
   logic [9:0]   held_sel;
   logic         held_before;
   logic         toggle;
   logic [9:0]   eff;
   logic [5:0]   mods;
   logic [6:0]   ch;
   sckd_rsp_type result;

   assign accept    = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      chan        = req_data.key_released;
      press       = !chan;
      chan_mask   = chan ? 2'b10 : 2'b01;
      is_prefix   = (req_data.raw_byte == PREFIX_BYTE);
      scan        = (req_data.raw_byte & SCAN_MASK) | (prefix_ff[chan] ? EXT_BIT : 8'h00);
      key         = scan_to_key(scan);
      mapped      = !is_prefix && (key != KEY_NONE);
      held_sel    = mapped ? held_mask(key) : 10'd0;
      held_before = |(held_sel & down_ff);
      toggle      = mapped && press && !held_before;
      lock_in     = lock_ff ^ {toggle && (key == KEY_NUM), toggle && (key == KEY_CAPS)};
      eff         = (down_ff & ~held_sel) | (held_sel & {10{press}});
      down_in     = eff;
      mods        = {lock_in, eff[3] | eff[7], eff[2] | eff[6], eff[1] | eff[5],
                     eff[0] | eff[4]};
      ch          = press ? key_char(key, mods) : 7'd0;
      prefix_in   = is_prefix ? (prefix_ff | chan_mask) : (prefix_ff & ~chan_mask);

      result = '0;
      if (mapped) begin
         result.key_valid     = 1'b1;
         result.key_code      = key;
         result.scan_code     = scan;
         result.key_action    = press;
         result.modifier_bits = mods;
         if (ch != 7'd0) begin
            result.char_valid   = 1'b1;
            result.char_code    = ch;
            result.char_is_text = (mods[3:1] == 3'b000);
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      if (out_adv) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
            out_in        = skid_ff;
         end else begin
            out_valid_in = accept;
            out_in       = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff     <= '0;
         lock_ff       <= '0;
         down_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            prefix_ff <= prefix_in;
            lock_ff   <= lock_in;
            down_ff   <= down_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (accept && !out_adv) begin
         skid_ff <= result;
      end
   end

endmodule

@@ src/sckd_checker.sv @@
// Port-level assertions for the scan code keyboard decoder, bound to the top level
`include "assert_macros.svh"

module sckd_assert (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input sckd_pkg::sckd_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input sckd_pkg::sckd_rsp_type rsp_data
);
   import sckd_pkg::*;

   logic req_seen;
   assign req_seen = req_valid && !req_stall && (req_data.raw_byte == req_data.raw_byte);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled rsp item changed")
   `ASSERT_NEVER(a_no_event_zero, clock, reset, rsp_valid && !rsp_data.key_valid && (rsp_data != '0), "rsp item without key event has nonzero fields")
   `ASSERT_NEVER(a_char_on_press, clock, reset, rsp_valid && rsp_data.char_valid && !(rsp_data.key_valid && rsp_data.key_action), "char reported without a key press")
   `ASSERT_NEVER(a_text_needs_char, clock, reset, rsp_valid && rsp_data.char_is_text && !rsp_data.char_valid, "text flag without char")
   `ASSERT_CLK(a_req_to_rsp, clock, reset, req_seen && !rsp_stall |=> rsp_valid, "accepted req item not shown on rsp")

endmodule

bind scancode_keyboard_decoder_unit sckd_assert u_sckd_assert (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
